@@ rtl/spr_pkg.sv @@
// Package: shared types and constants of the servo packet receiver.
package spr_pkg;

    localparam int unsigned LIMIT_W = 10;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned CRC_W   = 16;

    localparam logic [LIMIT_W-1:0] SIZE_LIMIT_RESET = 10'd255;
    localparam logic [7:0]         HDR_FF           = 8'hFF;
    localparam logic [7:0]         HDR_FD           = 8'hFD;
    localparam logic [CRC_W-1:0]   CRC_POLY         = 16'h8005;
    localparam logic [LEN_W-1:0]   MIN_LENGTH       = 16'd3;
    // count of the first parameter byte, from 1: after header(3), reserved, id, length(2), instruction
    localparam logic [LIMIT_W-1:0] PARAM_OFFSET     = 10'd9;
    // instruction plus two crc bytes plus one, so index + 4 reaching length is the last
    localparam logic [LEN_W:0]     PARAM_TAIL       = 17'd4;

    localparam int unsigned APB_ADDR_W = 3;
    localparam logic        REG_SIZE_LIMIT = 1'b0;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_FF1   = 4'd1,
        PH_FF2   = 4'd2,
        PH_RSV   = 4'd3,
        PH_ID    = 4'd4,
        PH_LEN1  = 4'd5,
        PH_LEN2  = 4'd6,
        PH_INSTR = 4'd7,
        PH_PARAM = 4'd8,
        PH_CRC1  = 4'd9,
        PH_CRC2  = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_PARAM     = 3'd1,
        ST_GOOD      = 3'd2,
        ST_BADCRC    = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_TIMEOUT   = 3'd5,
        ST_MALFORMED = 3'd6
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [7:0]           param_byte;
        logic [LIMIT_W-1:0]   param_index;
        logic [7:0]           packet_id;
        logic [7:0]           packet_instruction;
        logic [LEN_W-1:0]     packet_length;
    } result_t;

endpackage

@@ rtl/spr_if.sv @@
// Interfaces: received byte channel and report channel.
interface spr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       timeout;

    modport source (output valid, output rx_byte, output timeout, input ready);
    modport sink   (input valid, input rx_byte, input timeout, output ready);
endinterface

interface spr_report_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  param_byte;
    logic [9:0]  param_index;
    logic [7:0]  packet_id;
    logic [7:0]  packet_instruction;
    logic [15:0] packet_length;

    modport source (output valid, output status, output param_byte, output param_index,
                    output packet_id, output packet_instruction, output packet_length,
                    input ready);
    modport sink   (input valid, input status, input param_byte, input param_index,
                    input packet_id, input packet_instruction, input packet_length,
                    output ready);
endinterface

@@ rtl/spr_apb_cfg.sv @@
// APB configuration register block holding the size limit.
module spr_apb_cfg
    import spr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [LIMIT_W-1:0]    size_limit
);

    logic [LIMIT_W-1:0] size_limit_reg;
    logic [LIMIT_W-1:0] size_limit_next;
    logic               wr_en;
    logic               hit;

    assign pready = 1'b1;
    assign hit    = (paddr[APB_ADDR_W-1] == REG_SIZE_LIMIT);
    assign wr_en  = psel && penable && pwrite && hit;

    always_comb
    begin
        size_limit_next = size_limit_reg;
        if (wr_en)
        begin
            size_limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_limit_reg <= SIZE_LIMIT_RESET;
        end
        else
        begin
            size_limit_reg <= size_limit_next;
        end
    end

    assign prdata     = hit ? {{(32-LIMIT_W){1'b0}}, size_limit_reg} : 32'd0;
    assign size_limit = size_limit_reg;

endmodule

@@ rtl/spr_crc16.sv @@
// Byte-wide CRC-16 update, polynomial 0x8005, msb first.
module spr_crc16
    import spr_pkg::*;
(
    input  logic [CRC_W-1:0] crc_in,
    input  logic [7:0]       data,
    output logic [CRC_W-1:0] crc_out
);

    always_comb
    begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[CRC_W-1])
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

@@ rtl/spr_deframer.sv @@
// Packet deframer: header hunt, field capture, crc check and report decision.
module spr_deframer
    import spr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         rx_byte,
    input  logic               timeout,
    input  logic [LIMIT_W-1:0] size_limit,
    output result_t            result
);

    phase_t             phase_reg, phase_next;
    logic [LIMIT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [7:0]         crc_lo_reg, crc_lo_next;
    logic [7:0]         id_reg, id_next;
    logic [7:0]         instr_reg, instr_next;

    phase_t             ph;
    logic               fits;
    logic [LIMIT_W-1:0] count_base, count_inc;
    logic [LEN_W-1:0]   len_base, len_new;
    logic [CRC_W-1:0]   crc_base, crc_upd;
    logic [7:0]         id_base, instr_base;
    logic [LIMIT_W-1:0] pidx;

    spr_crc16 u_crc
    (
        .crc_in  (crc_base),
        .data    (rx_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        // unused phase codes behave as hunting
        case (phase_reg)
            PH_FF1, PH_FF2, PH_RSV, PH_ID, PH_LEN1, PH_LEN2,
            PH_INSTR, PH_PARAM, PH_CRC1, PH_CRC2: ph = phase_reg;
            default:                              ph = PH_HUNT;
        endcase
    end

    always_comb
    begin
        case (ph)
            PH_HUNT, PH_FF1: fits = (rx_byte == HDR_FF);
            PH_FF2:          fits = (rx_byte == HDR_FD);
            default:         fits = 1'b1;
        endcase
    end

    // a new packet starts from cleared fields
    assign count_base = (ph == PH_HUNT) ? '0 : count_reg;
    assign len_base   = (ph == PH_HUNT) ? '0 : len_reg;
    assign crc_base   = (ph == PH_HUNT) ? '0 : crc_reg;
    assign id_base    = (ph == PH_HUNT) ? '0 : id_reg;
    assign instr_base = (ph == PH_HUNT) ? '0 : instr_reg;
    assign count_inc  = count_base + 1'b1;
    assign len_new    = {rx_byte, len_base[7:0]};
    assign pidx       = count_inc - PARAM_OFFSET;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        id_next     = id_reg;
        instr_next  = instr_reg;
        result.status      = ST_BUSY;
        result.param_byte  = '0;
        result.param_index = '0;

        if (timeout)
        begin
            result.status = ST_TIMEOUT;
            phase_next    = PH_HUNT;
        end
        else if (!fits)
        begin
            // absorb extra FF before FD, otherwise drop back to hunting
            phase_next = (ph == PH_FF2 && rx_byte == HDR_FF) ? PH_FF2 : PH_HUNT;
        end
        else
        begin
            count_next = count_inc;
            len_next   = len_base;
            crc_next   = crc_base;
            id_next    = id_base;
            instr_next = instr_base;
            if (count_inc >= size_limit)
            begin
                result.status = ST_OVERFLOW;
                phase_next    = PH_HUNT;
            end
            else
            begin
                if (ph <= PH_PARAM)
                begin
                    crc_next = crc_upd;
                end
                case (ph)
                    PH_HUNT:  phase_next = PH_FF1;
                    PH_FF1:   phase_next = PH_FF2;
                    PH_FF2:   phase_next = PH_RSV;
                    PH_RSV:   phase_next = PH_ID;
                    PH_ID:
                    begin
                        id_next    = rx_byte;
                        phase_next = PH_LEN1;
                    end
                    PH_LEN1:
                    begin
                        len_next   = {{(LEN_W-8){1'b0}}, rx_byte};
                        phase_next = PH_LEN2;
                    end
                    PH_LEN2:
                    begin
                        len_next = len_new;
                        if (len_new < MIN_LENGTH)
                        begin
                            result.status = ST_MALFORMED;
                            phase_next    = PH_HUNT;
                        end
                        else
                        begin
                            phase_next = PH_INSTR;
                        end
                    end
                    PH_INSTR:
                    begin
                        instr_next = rx_byte;
                        phase_next = (len_base == MIN_LENGTH) ? PH_CRC1 : PH_PARAM;
                    end
                    PH_PARAM:
                    begin
                        result.status      = ST_PARAM;
                        result.param_byte  = rx_byte;
                        result.param_index = pidx;
                        if (({{(LEN_W+1-LIMIT_W){1'b0}}, pidx} + PARAM_TAIL)
                            >= {1'b0, len_base})
                        begin
                            phase_next = PH_CRC1;
                        end
                    end
                    PH_CRC1:
                    begin
                        crc_lo_next = rx_byte;
                        phase_next  = PH_CRC2;
                    end
                    default:
                    begin
                        result.status = ({rx_byte, crc_lo_reg} == crc_base) ? ST_GOOD
                                                                           : ST_BADCRC;
                        phase_next    = PH_HUNT;
                    end
                endcase
            end
        end

        result.packet_id          = id_next;
        result.packet_instruction = instr_next;
        result.packet_length      = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            count_reg  <= '0;
            len_reg    <= '0;
            crc_reg    <= '0;
            crc_lo_reg <= '0;
            id_reg     <= '0;
            instr_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
            id_reg     <= id_next;
            instr_reg  <= instr_next;
        end
    end

endmodule

@@ rtl/spr_out_reg.sv @@
// Output register holding one report until the receiver takes it.
module spr_out_reg
    import spr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    input  logic    taken,
    output logic    full,
    output result_t held
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign full = valid_reg;
    assign held = data_reg;

endmodule

@@ rtl/servo_packet_receiver_crc_check_top.sv @@
// Top level of the servo packet receiver with CRC-16 check.
//
// Channels: byte_ch carries one received byte per item, or a timeout marker
// (timeout high, byte ignored). report_ch carries exactly one report per
// accepted item: busy, a parameter byte with its index, packet good, crc
// mismatch, overflow, timeout or malformed length, together with the id,
// instruction and length field of the current packet.
// The APB port holds one register, size_limit, at byte address 0; a packet
// whose byte count reaches it is reported as overflowed.
// A report is registered, valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless a report stalls, set by the deframer
// step (byte-wide CRC update and phase decision) feeding the output register.
// Stall: while a report waits in the output register and report_ch.ready is
// low, byte_ch.ready is low; when the report is taken a new item may be
// accepted in the same cycle.
// Reset: the deframer hunts for the header with all its fields zero,
// size_limit is 255 and the output register is empty.
module servo_packet_receiver_crc_check_top
    import spr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    spr_byte_if.sink              byte_ch,
    spr_report_if.source          report_ch
);

    logic [LIMIT_W-1:0] size_limit;
    logic               take;
    logic               full;
    result_t            result;
    result_t            held;

    spr_apb_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .size_limit (size_limit)
    );

    // accept while the output slot is empty or being emptied this cycle
    assign byte_ch.ready = !full || report_ch.ready;
    assign take          = byte_ch.valid && byte_ch.ready;

    spr_deframer u_deframer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .rx_byte    (byte_ch.rx_byte),
        .timeout    (byte_ch.timeout),
        .size_limit (size_limit),
        .result     (result)
    );

    spr_out_reg u_out
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (take),
        .result (result),
        .taken  (report_ch.ready),
        .full   (full),
        .held   (held)
    );

    assign report_ch.valid              = full;
    assign report_ch.status             = held.status;
    assign report_ch.param_byte         = held.param_byte;
    assign report_ch.param_index        = held.param_index;
    assign report_ch.packet_id          = held.packet_id;
    assign report_ch.packet_instruction = held.packet_instruction;
    assign report_ch.packet_length      = held.packet_length;

    // every accepted item yields a report in the next cycle
    a_item_reports: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> report_ch.valid)
        else $error("accepted item produced no report");

    // a timeout marker always reports timeout
    a_timeout_report: assert property (@(posedge clk) disable iff (!rst_n)
        (take && byte_ch.timeout) |=> (report_ch.status == ST_TIMEOUT))
        else $error("timeout item did not report timeout");

    // a waiting report blocks new items
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (report_ch.valid && !report_ch.ready) |-> !byte_ch.ready)
        else $error("item accepted while report stalled");

    // parameter fields are zero outside parameter reports
    a_param_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (report_ch.valid && report_ch.status != ST_PARAM)
            |-> (report_ch.param_byte == 8'd0 && report_ch.param_index == 10'd0))
        else $error("parameter fields set outside a parameter report");

endmodule
